>>> hdl/pspc_pkg.sv
// Package for pair_sum_positive_counter: sizes, shared types and state codes.
package pspc_pkg;

    localparam int VALUE_BITS = 10;
    localparam int MAX_ITEMS  = 1024;

    localparam int TREE_BITS = VALUE_BITS + 1;
    localparam int TREE_LEN  = 2 ** TREE_BITS;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    localparam int PAIRS_W = 10;
    localparam int TOTAL_W = 19;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [TREE_BITS-1:0]  tree_addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    // write port of the count tree memory
    typedef struct packed {
        logic       en;
        tree_addr_t addr;
        cnt_t       data;
    } ram_wr_t;

    // one finished result from the sequencer
    typedef struct packed {
        logic [PAIRS_W-1:0] pairs_for_item;
        logic [TOTAL_W-1:0] total_pairs;
        logic               overflow;
    } result_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CLEAR  = 6'b000010,
        ST_CHECK  = 6'b000100,
        ST_QUERY  = 6'b001000,
        ST_UPDATE = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

endpackage

>>> hdl/pair_sum_positive_counter.sv
// Top level of pair_sum_positive_counter: sequencer, count tree memory, output register.
//
// Each transfer (start_req, value_a, value_b) forms d = a - b, counts the earlier
// differences e of the current set with e + d > 0, then adds d to the set. The set
// is a binary indexed tree of per-difference counts in a 2048-entry memory with one
// write and one registered read port. An item takes the prefix-query walk (one tree
// level per cycle) plus the update walk (read and write-back overlapped) plus the
// accept, check and hand-off steps; a full set skips both walks. Items are handled
// one at a time. After reset a clearing sweep writes zero to all 2048 entries, one
// per cycle, before the first transfer is taken. An item with start_req set runs
// the same sweep after it is taken and before its own walks; input is not taken
// during a sweep. Once MAX_ITEMS items are in the set, further items return
// overflow = 1, zero pairs and the unchanged total. Results sit in an output
// register so the next item can be taken while a result waits.
module pair_sum_positive_counter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         start_req,
    input  logic [pspc_pkg::VALUE_BITS-1:0] value_a,
    input  logic [pspc_pkg::VALUE_BITS-1:0] value_b,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [pspc_pkg::PAIRS_W-1:0] pairs_for_item,
    output logic [pspc_pkg::TOTAL_W-1:0] total_pairs,
    output logic                         overflow
);

    pspc_pkg::tree_addr_t ram_rd_addr;
    pspc_pkg::cnt_t       ram_rd_data;
    pspc_pkg::ram_wr_t    ram_wr;
    pspc_pkg::result_t    res;
    logic                 res_valid;
    logic                 res_ready;

    logic                 out_valid_reg;
    pspc_pkg::result_t    out_reg;

    pspc_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .start_req   (start_req),
        .value_a     (value_a),
        .value_b     (value_b),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .ram_wr      (ram_wr),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    pspc_tree_ram u_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // load the output register when it is empty or being drained this cycle
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pairs_for_item = out_reg.pairs_for_item;
    assign total_pairs    = out_reg.total_pairs;
    assign overflow       = out_reg.overflow;

endmodule

>>> hdl/pspc_tree_ram.sv
// Count tree memory: one write port, one read port, registered read data.
module pspc_tree_ram (
    input  logic                clk,
    input  pspc_pkg::ram_wr_t   wr,
    input  pspc_pkg::tree_addr_t rd_addr,
    output pspc_pkg::cnt_t      rd_data
);

    pspc_pkg::cnt_t mem [pspc_pkg::TREE_LEN];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hdl/pspc_seq.sv
// Sequencer: clear sweep, prefix query and update walks over the count tree.
module pspc_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  start_req,
    input  pspc_pkg::value_t      value_a,
    input  pspc_pkg::value_t      value_b,
    output pspc_pkg::tree_addr_t  ram_rd_addr,
    input  pspc_pkg::cnt_t        ram_rd_data,
    output pspc_pkg::ram_wr_t     ram_wr,
    output logic                  res_valid,
    input  logic                  res_ready,
    output pspc_pkg::result_t     res
);

    localparam pspc_pkg::tree_addr_t HALF = pspc_pkg::tree_addr_t'(1) << pspc_pkg::VALUE_BITS;
    localparam pspc_pkg::tree_addr_t LAST = '1;
    localparam pspc_pkg::cnt_t       FULL = pspc_pkg::cnt_t'(pspc_pkg::MAX_ITEMS);

    pspc_pkg::state_t             state_reg, state_next;
    logic                         pend_reg, pend_next;
    logic                         go_reg, go_next;
    logic                         ovf_reg, ovf_next;
    pspc_pkg::tree_addr_t         qpos_reg, qpos_next;
    logic [pspc_pkg::TREE_BITS:0] upos_reg, upos_next;
    pspc_pkg::tree_addr_t         wpos_reg, wpos_next;
    pspc_pkg::tree_addr_t         clr_reg, clr_next;
    pspc_pkg::cnt_t               sum_reg, sum_next;
    pspc_pkg::cnt_t               pairs_reg, pairs_next;
    pspc_pkg::cnt_t               items_reg, items_next;
    logic [pspc_pkg::TOTAL_W-1:0] total_reg, total_next;

    pspc_pkg::cnt_t               sum_acc;
    logic                         upos_ok;
    logic [pspc_pkg::TREE_BITS:0] upos_low;

    always_comb
    begin
        sum_acc  = sum_reg + (pend_reg ? ram_rd_data : '0);
        upos_ok  = (upos_reg != '0) && !upos_reg[pspc_pkg::TREE_BITS];
        upos_low = upos_reg & (~upos_reg + 1'b1);

        state_next = state_reg;
        pend_next  = pend_reg;
        go_next    = go_reg;
        ovf_next   = ovf_reg;
        qpos_next  = qpos_reg;
        upos_next  = upos_reg;
        wpos_next  = wpos_reg;
        clr_next   = clr_reg;
        sum_next   = sum_reg;
        pairs_next = pairs_reg;
        items_next = items_reg;
        total_next = total_reg;

        in_ready    = 1'b0;
        res_valid   = 1'b0;
        ram_rd_addr = '0;
        ram_wr.en   = 1'b0;
        ram_wr.addr = wpos_reg;
        ram_wr.data = ram_rd_data + 1'b1;

        case (state_reg)
            pspc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    // tree position of threshold + 1 and of slot + 1
                    qpos_next = HALF + pspc_pkg::tree_addr_t'(value_b)
                              - pspc_pkg::tree_addr_t'(value_a);
                    upos_next = {1'b0, HALF + pspc_pkg::tree_addr_t'(value_a)
                              - pspc_pkg::tree_addr_t'(value_b)};
                    if (start_req)
                    begin
                        items_next = '0;
                        total_next = '0;
                        clr_next   = '0;
                        go_next    = 1'b1;
                        state_next = pspc_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        state_next = pspc_pkg::ST_CHECK;
                    end
                end
            end
            pspc_pkg::ST_CLEAR:
            begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = clr_reg;
                ram_wr.data = '0;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == LAST)
                begin
                    state_next = go_reg ? pspc_pkg::ST_CHECK : pspc_pkg::ST_IDLE;
                end
            end
            pspc_pkg::ST_CHECK:
            begin
                sum_next  = '0;
                pend_next = 1'b0;
                if (items_reg == FULL)
                begin
                    ovf_next   = 1'b1;
                    pairs_next = '0;
                    state_next = pspc_pkg::ST_DONE;
                end
                else
                begin
                    ovf_next   = 1'b0;
                    state_next = pspc_pkg::ST_QUERY;
                end
            end
            pspc_pkg::ST_QUERY:
            begin
                ram_rd_addr = qpos_reg;
                sum_next    = sum_acc;
                if (qpos_reg != '0)
                begin
                    qpos_next = qpos_reg & (qpos_reg - 1'b1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    pairs_next = items_reg - sum_acc;
                    state_next = pspc_pkg::ST_UPDATE;
                end
            end
            pspc_pkg::ST_UPDATE:
            begin
                ram_rd_addr = upos_reg[pspc_pkg::TREE_BITS-1:0];
                ram_wr.en   = pend_reg;
                if (upos_ok)
                begin
                    wpos_next = upos_reg[pspc_pkg::TREE_BITS-1:0];
                    upos_next = upos_reg + upos_low;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    items_next = items_reg + 1'b1;
                    total_next = total_reg + pspc_pkg::TOTAL_W'(pairs_reg);
                    state_next = pspc_pkg::ST_DONE;
                end
            end
            pspc_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
                go_next   = 1'b0;
                if (res_ready)
                begin
                    state_next = pspc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pspc_pkg::ST_IDLE;
            end
        endcase
    end

    assign res.pairs_for_item = pspc_pkg::PAIRS_W'(pairs_reg);
    assign res.total_pairs    = total_reg;
    assign res.overflow       = ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pspc_pkg::ST_CLEAR;
            pend_reg  <= 1'b0;
            go_reg    <= 1'b0;
            clr_reg   <= '0;
            items_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            go_reg    <= go_next;
            clr_reg   <= clr_next;
            items_reg <= items_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg   <= ovf_next;
        qpos_reg  <= qpos_next;
        upos_reg  <= upos_next;
        wpos_reg  <= wpos_next;
        sum_reg   <= sum_next;
        pairs_reg <= pairs_next;
    end

endmodule

>>> tb/tb_pair_sum_positive_counter.sv
// Testbench for pair_sum_positive_counter: directed and random transfers checked by a scoreboard.
module tb_pair_sum_positive_counter;

    import pspc_pkg::*;

    // Scoreboard: keeps its own copy of the set as a plain list of differences
    // and predicts each result when the input transfer is taken.
    class pair_count_board;
        int      set_diffs[$];
        longint  running_total;
        result_t pending_results[$];
        int      errors;

        function new();
            set_diffs.delete();
            running_total = 0;
            errors = 0;
        endfunction

        // Predict the result of one accepted item and queue it.
        function void note_item(logic clear_set, value_t a, value_t b);
            int      d;
            int      hits;
            result_t want;
            if (clear_set)
            begin
                set_diffs.delete();
                running_total = 0;
            end
            d = int'(a) - int'(b);
            hits = 0;
            if (set_diffs.size() >= MAX_ITEMS)
            begin
                want.overflow = 1'b1;
            end
            else
            begin
                foreach (set_diffs[i])
                    if (set_diffs[i] + d > 0)
                        hits++;
                running_total += hits;
                set_diffs.push_back(d);
                want.overflow = 1'b0;
            end
            want.pairs_for_item = PAIRS_W'(hits);
            want.total_pairs    = TOTAL_W'(running_total);
            pending_results.push_back(want);
        endfunction

        // Compare one result transfer with the oldest prediction.
        function void check_result(logic [PAIRS_W-1:0] pairs, logic [TOTAL_W-1:0] total,
                                   logic ovf);
            result_t want;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: pairs_for_item=%0d total_pairs=%0d overflow=%0d",
                       pairs, total, ovf);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (want.pairs_for_item !== pairs)
            begin
                $error("pairs_for_item: expected %0d, got %0d", want.pairs_for_item, pairs);
                errors++;
            end
            if (want.total_pairs !== total)
            begin
                $error("total_pairs: expected %0d, got %0d", want.total_pairs, total);
                errors++;
            end
            if (want.overflow !== ovf)
            begin
                $error("overflow: expected %0d, got %0d", want.overflow, ovf);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT hookup. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic                 start_req = 1'b0;
    value_t               value_a   = '0;
    value_t               value_b   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [PAIRS_W-1:0]   pairs_for_item;
    logic [TOTAL_W-1:0]   total_pairs;
    logic                 overflow;

    pair_count_board board = new();

    // sender burst shaping: transfers left in the current burst
    int burst_left = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    pair_sum_positive_counter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .start_req      (start_req),
        .value_a        (value_a),
        .value_b        (value_b),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pairs_for_item (pairs_for_item),
        .total_pairs    (total_pairs),
        .overflow       (overflow)
    );

    // ------------------------------------------------------------------
    // Input side. Called at a rising edge; returns at the edge where the transfer
    // happened, or after the idle gap if one follows. Valid is only dropped when a
    // gap follows, so a back-to-back transfer never sees valid lowered and raised in one step.
    // ------------------------------------------------------------------
    task automatic send_item(input logic clear_set, input value_t a, input value_t b);
        int gap;
        in_valid  <= 1'b1;
        start_req <= clear_set;
        value_a   <= a;
        value_b   <= b;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_item(clear_set, a, b);
        if (burst_left == 0)
        begin
            // end of burst: idle for a while, then pick the next burst length
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 15);
        end
        else
        begin
            burst_left--;
        end
    endtask

    // Operand picker per set flavor:
    //   0 - full range
    //   1 - narrow band around mid-scale, so differences tie and cancel often
    //   2 - heavy on the extremes
    function automatic value_t pick_value(int flavor);
        case (flavor)
            1:       return value_t'($urandom_range(508, 515));
            2:       return ($urandom_range(0, 2) == 0) ? value_t'($urandom_range(0, 1023))
                                                        : ($urandom_range(0, 1) ? '1 : '0);
            default: return value_t'($urandom_range(0, 1023));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Output side: check each result transfer, then drive out_ready from
    // a mode that is picked anew at random (always ready, coin flip, sparse
    // periodic, long stalls).
    // ------------------------------------------------------------------
    initial
    begin
        int stall_mode;
        int mode_left;
        int cyc;
        logic rdy;
        stall_mode = 0;
        mode_left  = 0;
        cyc        = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                board.check_result(pairs_for_item, total_pairs, overflow);
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(64, 400);
            end
            mode_left--;
            cyc++;
            case (stall_mode)
                0:       rdy = 1'b1;
                1:       rdy = $urandom_range(0, 1);
                2:       rdy = (cyc % 5 == 0);
                default: rdy = ($urandom_range(0, 23) == 0);
            endcase
            out_ready <= rdy;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: directed corners first, then random sets. One set runs
    // past MAX_ITEMS so the full-set path gets exercised under traffic.
    // ------------------------------------------------------------------
    initial
    begin
        int left_items;
        int set_len;
        int flavor;
        int set_no;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // extremes, zero difference, cancelling pairs (e + d == 0 is not counted)
        send_item(1'b1, 10'd0,    10'd0);
        send_item(1'b0, 10'd1023, 10'd0);
        send_item(1'b0, 10'd0,    10'd1023);
        send_item(1'b0, 10'd1023, 10'd1023);
        send_item(1'b0, 10'd5,    10'd0);
        send_item(1'b0, 10'd0,    10'd5);
        send_item(1'b0, 10'd0,    10'd4);
        send_item(1'b0, 10'd6,    10'd0);
        // fresh set opening with the largest difference
        send_item(1'b1, 10'd1023, 10'd0);
        send_item(1'b0, 10'd0,    10'd1023);
        send_item(1'b0, 10'd0,    10'd1023);
        send_item(1'b0, 10'd1023, 10'd0);
        send_item(1'b0, 10'd1,    10'd0);
        // alternating bit patterns on both operands
        send_item(1'b1, 10'h2AA,  10'h155);
        send_item(1'b0, 10'h155,  10'h2AA);
        send_item(1'b0, 10'h3FF,  10'h3FE);
        send_item(1'b0, 10'h3FE,  10'h3FF);
        send_item(1'b0, 10'd512,  10'd512);
        send_item(1'b0, 10'd0,    10'd1);
        // back-to-back set starts
        send_item(1'b1, 10'd700,  10'd300);
        send_item(1'b1, 10'd300,  10'd700);

        left_items = 1130;
        set_no     = 0;
        while (left_items > 0)
        begin
            if (set_no == 1)
                set_len = MAX_ITEMS + $urandom_range(4, 24);
            else
                set_len = $urandom_range(1, 48);
            if (set_len > left_items)
                set_len = left_items;
            flavor = $urandom_range(0, 2);
            // a stray mid-set restart now and then, but never in the long set
            for (int k = 0; k < set_len; k++)
                send_item(k == 0 || (set_no != 1 && $urandom_range(0, 63) == 0),
                          pick_value(flavor), pick_value(flavor));
            left_items -= set_len;
            set_no++;
        end
        in_valid <= 1'b0;

        // drain outstanding results, then a short settle
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog, well above the slowest legal run.
    initial
    begin
        #(8 * 3000000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
